// ===== rtl/pdt_pkg.sv =====
// Shared types and constants for the periodic deadline trigger.
package pdt_pkg;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    // 2^32 seconds expressed in nanoseconds, used for deadline second bit 32
    localparam logic [61:0] SEC_HI_NS  = 62'd4294967296000000000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT = 2'd2;

    localparam logic [29:0] PERIOD_RESET = 30'd1000000;

    localparam int DIV_STEPS = 30;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [31:0] sample_sec;
        logic [29:0] sample_nsec;
        logic        keep_running;
    } pdt_in_t;

    typedef struct packed {
        logic        fired;
        logic [61:0] sample_total_ns;
        logic [61:0] deadline_total_ns;
        logic [15:0] trigger_index;
        logic        finished;
    } pdt_out_t;

    typedef struct packed {
        logic [29:0] period_ns;
        logic        schedule_mode;
        logic [15:0] run_limit;
    } pdt_cfg_t;

    typedef struct packed {
        logic cap_in;      // latch input beat
        logic eval;        // latch fire / arm decision
        logic mul_go;      // load product register
        logic mul_dl;      // multiplier operand: 1 deadline seconds, 0 sample seconds
        logic met_add;     // build deadline total
        logic strict_load; // work = deadline (sample when arming) + period
        logic div_load;    // start remainder
        logic div_step;    // one restoring step
        logic fix;         // work = sample + period - remainder
        logic norm_step;   // subtract one second of nanoseconds
        logic commit;      // write new deadline and counters
        logic out_load;    // load result register
    } pdt_cmd_t;

    typedef struct packed {
        logic armed;
        logic fire;
        logic fire_q;
        logic arm_q;
        logic strict;
        logic norm_big;
        logic out_free;
    } pdt_status_t;

endpackage

// ===== rtl/pdt_cfg_regs.sv =====
// Configuration register file for the periodic deadline trigger.
module pdt_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pdt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output pdt_pkg::pdt_cfg_t              cfg
);
    import pdt_pkg::*;

    pdt_cfg_t cfg_reg;
    pdt_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PERIOD:    cfg_next.period_ns     = cfg_wdata[29:0];
                CFG_MODE:      cfg_next.schedule_mode = cfg_wdata[0];
                CFG_RUN_LIMIT: cfg_next.run_limit     = cfg_wdata[15:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ns     <= PERIOD_RESET;
            cfg_reg.schedule_mode <= 1'b0;
            cfg_reg.run_limit     <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/pdt_ctrl.sv =====
// Sequencing state machine for the periodic deadline trigger.
module pdt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pdt_pkg::pdt_status_t  status,
    output pdt_pkg::pdt_cmd_t     cmd
);
    import pdt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MULD,
        ST_DADD,
        ST_START,
        ST_DIV,
        ST_FIX,
        ST_NORM,
        ST_MULS,
        ST_SADD
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIV_CNT_W-1:0]  cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.cap_in = in_valid;
                if (in_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                // first beat after reset arms; no deadline to report yet
                state_next = status.armed ? ST_MULD : ST_START;
            end
            ST_MULD:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_dl = 1'b1;
                state_next = ST_DADD;
            end
            ST_DADD:
            begin
                cmd.met_add = 1'b1;
                state_next  = status.fire_q ? ST_START : ST_MULS;
            end
            ST_START:
            begin
                if (status.strict)
                begin
                    cmd.strict_load = 1'b1;
                    state_next      = ST_NORM;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    cnt_next     = DIV_CNT_W'(DIV_STEPS - 1);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if (status.norm_big)
                begin
                    cmd.norm_step = 1'b1;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    // arming reports the new deadline, so fetch it after the write
                    state_next = status.arm_q ? ST_MULD : ST_MULS;
                end
            end
            ST_MULS:
            begin
                cmd.mul_go = 1'b1;
                state_next = ST_SADD;
            end
            ST_SADD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START) && !status.strict
        |=> (state_reg == ST_DIV) ##30 (state_reg == ST_FIX))
        else $error("remainder did not take the full step count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result register loaded while a beat is pending");

    a_arm_fire_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM) |-> !(status.fire_q && status.arm_q))
        else $error("arming beat marked as fired");

endmodule

// ===== rtl/pdt_datapath.sv =====
// Datapath: sample/deadline registers, shared multiplier, remainder unit, carry fix.
module pdt_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdt_pkg::pdt_cfg_t     cfg,
    input  pdt_pkg::pdt_cmd_t     cmd,
    output pdt_pkg::pdt_status_t  status,
    input  pdt_pkg::pdt_in_t      in_data,
    output pdt_pkg::pdt_out_t     out_data,
    output logic                  out_valid,
    input  logic                  out_ready
);
    import pdt_pkg::*;

    // captured sample
    logic [31:0] ssec_reg;
    logic [29:0] snsec_reg;
    logic        keep_reg;
    logic [15:0] idx_reg;
    logic        fire_q_reg;
    logic        arm_q_reg;

    // architectural state
    logic [32:0] dsec_reg;
    logic [29:0] dnsec_reg;
    logic        armed_reg;
    logic [15:0] count_reg;
    logic        stopped_reg;

    // working registers
    logic [61:0] prod_reg;
    logic [61:0] met_reg;
    logic [29:0] rem_reg;
    logic [29:0] dvd_reg;
    logic [32:0] wsec_reg;
    logic [30:0] wnsec_reg;

    pdt_out_t    out_reg;
    logic        out_valid_reg;

    logic [29:0] eff_p;
    logic [31:0] mul_a;
    logic [30:0] rem_sh;
    logic        rem_ge;
    logic [29:0] rem_next;
    logic        after_dl;
    logic        finished;
    logic        norm_big;

    assign eff_p    = (cfg.period_ns == '0) ? 30'd1 : cfg.period_ns;
    assign mul_a    = cmd.mul_dl ? dsec_reg[31:0] : ssec_reg;
    assign rem_sh   = {rem_reg, dvd_reg[29]};
    assign rem_ge   = rem_sh >= {1'b0, eff_p};
    assign rem_next = rem_ge ? 30'(rem_sh - {1'b0, eff_p}) : rem_sh[29:0];
    assign after_dl = ({1'b0, ssec_reg} > dsec_reg) ||
                      (({1'b0, ssec_reg} == dsec_reg) && (snsec_reg >= dnsec_reg));
    assign finished = stopped_reg || (count_reg >= cfg.run_limit);
    assign norm_big = wnsec_reg >= 31'(NS_PER_SEC);

    always_comb
    begin
        status.armed    = armed_reg;
        status.fire     = armed_reg && !finished && after_dl;
        status.fire_q   = fire_q_reg;
        status.arm_q    = arm_q_reg;
        status.strict   = cfg.schedule_mode;
        status.norm_big = norm_big;
        status.out_free = !out_valid_reg || out_ready;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            ssec_reg  <= in_data.sample_sec;
            snsec_reg <= in_data.sample_nsec;
            keep_reg  <= in_data.keep_running;
            idx_reg   <= count_reg;
        end
        if (cmd.eval)
        begin
            fire_q_reg <= status.fire;
            arm_q_reg  <= !armed_reg;
        end
        if (cmd.mul_go)
            prod_reg <= mul_a * NS_PER_SEC;
        if (cmd.met_add)
            met_reg <= prod_reg + (dsec_reg[32] ? SEC_HI_NS : 62'd0) + 62'(dnsec_reg);
        if (cmd.div_load)
        begin
            rem_reg <= '0;
            dvd_reg <= snsec_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[28:0], 1'b0};
        end
        if (cmd.strict_load)
        begin
            // arming starts from the sample, a fire from the old deadline
            wsec_reg  <= arm_q_reg ? {1'b0, ssec_reg} : dsec_reg;
            wnsec_reg <= (arm_q_reg ? 31'(snsec_reg) : 31'(dnsec_reg)) + 31'(eff_p);
        end
        else if (cmd.fix)
        begin
            // next multiple of the period above the sample nanoseconds
            wsec_reg  <= {1'b0, ssec_reg};
            wnsec_reg <= 31'(snsec_reg) + 31'(eff_p) - 31'(rem_reg);
        end
        else if (cmd.norm_step)
        begin
            wsec_reg  <= wsec_reg + 33'd1;
            wnsec_reg <= wnsec_reg - 31'(NS_PER_SEC);
        end
        if (cmd.out_load)
        begin
            out_reg.fired             <= fire_q_reg;
            out_reg.sample_total_ns   <= prod_reg + 62'(snsec_reg);
            out_reg.deadline_total_ns <= met_reg;
            out_reg.trigger_index     <= idx_reg;
            out_reg.finished          <= finished;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dsec_reg      <= '0;
            dnsec_reg     <= '0;
            armed_reg     <= 1'b0;
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                dsec_reg  <= wsec_reg;
                dnsec_reg <= wnsec_reg[29:0];
                armed_reg <= 1'b1;
                if (fire_q_reg)
                begin
                    count_reg <= count_reg + 16'd1;
                    if (!keep_reg)
                        stopped_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

    a_commit_norm: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (wnsec_reg < 31'(NS_PER_SEC)))
        else $error("deadline committed with nanoseconds out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && fire_q_reg |=> count_reg == $past(count_reg) + 16'd1)
        else $error("trigger count did not advance on a fire");

endmodule

// ===== rtl/periodic_deadline_trigger.sv =====
// Top level of the periodic deadline trigger.
// Usage:
//   in channel (in_valid/in_ready/in_data): one beat per time sample, seconds plus
//   nanoseconds and the handler's keep_running answer.
//   out channel (out_valid/out_ready/out_data): exactly one result beat per input beat,
//   in order: fired flag, sample and deadline as total nanoseconds, trigger index,
//   finished flag.
//   cfg port: cfg_we writes cfg_wdata into register cfg_index (0 period, 1 schedule
//   mode, 2 run limit); write only while no beat is in flight.
// Timing:
//   A beat that neither arms nor fires runs evaluation, the deadline product and total
//   and the sample product. Arming or firing in strict mode adds the period to the
//   sample or old deadline; aligned mode runs the restoring remainder unit and fix step.
//   The carry fix then removes one whole second per step (at most two).
//   One beat is processed at a time; in_ready is high only while the sequencer waits,
//   so the next beat is taken at the earliest in the cycle after the result loads.
// Reset clears the deadline, the trigger count and the stop flag; the first sample
// afterwards arms the first deadline. A stalled receiver holds the result register;
// the next sample is still accepted and processed up to its result, which then waits.
module periodic_deadline_trigger (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pdt_pkg::pdt_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pdt_pkg::pdt_out_t              out_data,
    input  logic                           cfg_we,
    input  logic [pdt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pdt_pkg::*;

    pdt_cfg_t    cfg;
    pdt_cmd_t    cmd;
    pdt_status_t status;

    pdt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pdt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule
